FILE: src/gbn_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_pkg
// Shared types and constants for the greedy box NMS core.
// ----------------------------------------------------------------------------
package gbn_pkg;

  localparam int FIELD_W = 16;
  localparam int THR_W   = 16;
  localparam int POS_W   = 16;
  localparam int UNI_W   = 64;   // union and product are kept modulo 2^64
  localparam int KA_MAX_W = 32;  // stored areas are truncated to 32 bits

  localparam logic [THR_W-1:0] THR_RESET = 16'd29491;

  typedef struct packed {
    logic               start_of_set;
    logic [FIELD_W-1:0] box_left;
    logic [FIELD_W-1:0] box_top;
    logic [FIELD_W-1:0] box_width;
    logic [FIELD_W-1:0] box_height;
  } in_item_t;

  typedef struct packed {
    logic             kept;
    logic [POS_W-1:0] box_position;
    logic             store_overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AREA,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;       // capture input word
    logic calc_area;  // compute area of the new box
    logic issue;      // read one kept entry into the compare pipe
    logic finish;     // store box, emit result
  } ctl_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic scan_last;
    logic pipe_busy;
  } dp_stat_t;

endpackage

FILE: src/gbn_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_ctrl
// Sequencer: accepts a word, scans the kept store, drains the compare pipe
// and closes out the result.
// ----------------------------------------------------------------------------
module gbn_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gbn_pkg::dp_stat_t stat,
  output gbn_pkg::ctl_cmd_t cmd
);
  import gbn_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_AREA;
        end
      end
      ST_AREA: begin
        cmd.calc_area = 1'b1;
        state_nxt     = stat.count_zero ? ST_DRAIN : ST_SCAN;
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!stat.pipe_busy) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: src/gbn_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_datapath
// Kept-box store, counters and the pipelined IoU compare against one
// stored box per cycle.
// ----------------------------------------------------------------------------
module gbn_datapath #(
  parameter int MAX_KEPT   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  gbn_pkg::in_item_t                   in_item,
  input  logic                                cfg_we,
  input  logic [gbn_pkg::THR_W-1:0]           cfg_wdata,
  input  gbn_pkg::ctl_cmd_t                   cmd,
  output gbn_pkg::dp_stat_t                   stat,
  output logic                                out_strobe,
  output gbn_pkg::out_item_t                  out_item
);
  import gbn_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int IDX_W  = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W  = $clog2(MAX_KEPT + 1);
  localparam int AREA_W = 2 * CB;
  localparam int KA_W   = (AREA_W < KA_MAX_W) ? AREA_W : KA_MAX_W;
  localparam int BOX_W  = 4 * CB;
  localparam int NSTG   = 6;
  localparam int LO_W   = UNI_W / 2;
  localparam int PPL_W  = THR_W + LO_W;

  // configuration
  logic [THR_W-1:0] thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_r <= cfg_wdata;
    end
  end

  // current box
  logic [CB-1:0]     cur_l_r, cur_t_r, cur_w_r, cur_h_r;
  logic [AREA_W-1:0] area_r;
  logic [CNT_W-1:0]  count_r;
  logic [POS_W-1:0]  pos_r;
  logic [IDX_W-1:0]  idx_r;
  logic              suppress_r;
  logic              full;
  logic              keep;

  // compare pipe
  logic [NSTG-1:0]   v_r;
  logic [CB-1:0]     o_l, o_t, o_w, o_h;
  logic [CB-1:0]     iw_r, ih_r;
  logic [KA_W-1:0]   ka1_r, ka2_r;
  logic [AREA_W-1:0] inter_r;
  logic [UNI_W-1:0]  uni_r, ish_r, ish2_r, ish3_r;
  logic [PPL_W-1:0]  pp_lo_r;
  logic [LO_W-1:0]   pp_hi_r;
  logic [UNI_W-1:0]  prod_r;

  assign full = (count_r == CNT_W'(MAX_KEPT));
  assign keep = !suppress_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_l_r <= CB'(in_item.box_left);
      cur_t_r <= CB'(in_item.box_top);
      cur_w_r <= CB'(in_item.box_width);
      cur_h_r <= CB'(in_item.box_height);
    end
    if (cmd.calc_area) begin
      area_r <= AREA_W'(cur_w_r) * AREA_W'(cur_h_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      pos_r      <= '0;
      idx_r      <= '0;
      suppress_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        idx_r      <= '0;
        suppress_r <= 1'b0;
        if (in_item.start_of_set) begin
          count_r <= '0;
          pos_r   <= '0;
        end
      end
      if (cmd.issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.finish) begin
        pos_r <= pos_r + 1'b1;
        if (keep && !full) begin
          count_r <= count_r + 1'b1;
        end
      end
      if (v_r[NSTG-1] && (ish3_r > prod_r)) begin
        suppress_r <= 1'b1;
      end
    end
  end

  // kept store
  logic [BOX_W-1:0] box_mem  [MAX_KEPT];
  logic [KA_W-1:0]  area_mem [MAX_KEPT];
  logic [BOX_W-1:0] rd_box_r;
  logic [KA_W-1:0]  rd_area_r;

  always_ff @(posedge clk) begin
    if (cmd.finish && keep && !full) begin
      box_mem[count_r[IDX_W-1:0]]  <= {cur_l_r, cur_t_r, cur_w_r, cur_h_r};
      area_mem[count_r[IDX_W-1:0]] <= area_r[KA_W-1:0];
    end
    if (cmd.issue) begin
      rd_box_r  <= box_mem[idx_r];
      rd_area_r <= area_mem[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NSTG-2:0], cmd.issue};
    end
  end

  function automatic logic [CB-1:0] overlap_len(input logic [CB-1:0] a0,
                                                input logic [CB-1:0] alen,
                                                input logic [CB-1:0] b0,
                                                input logic [CB-1:0] blen);
    logic [CB:0] a1, b1, lo, hi, diff;
    a1   = {1'b0, a0} + {1'b0, alen};
    b1   = {1'b0, b0} + {1'b0, blen};
    lo   = (a0 > b0) ? {1'b0, a0} : {1'b0, b0};
    hi   = (a1 < b1) ? a1 : b1;
    diff = (hi > lo) ? (hi - lo) : '0;
    return diff[CB-1:0];
  endfunction

  assign {o_l, o_t, o_w, o_h} = rd_box_r;

  always_ff @(posedge clk) begin
    // overlap extents
    iw_r  <= overlap_len(cur_l_r, cur_w_r, o_l, o_w);
    ih_r  <= overlap_len(cur_t_r, cur_h_r, o_t, o_h);
    ka1_r <= rd_area_r;
    // intersection area
    inter_r <= AREA_W'(iw_r) * AREA_W'(ih_r);
    ka2_r   <= ka1_r;
    // union, wraps like the 64-bit reference arithmetic
    uni_r <= UNI_W'(area_r) + UNI_W'(ka2_r) - UNI_W'(inter_r);
    ish_r <= UNI_W'(inter_r) << THR_W;
    // threshold * union in two halves
    pp_lo_r <= PPL_W'(thr_r) * PPL_W'(uni_r[LO_W-1:0]);
    pp_hi_r <= LO_W'(thr_r) * uni_r[UNI_W-1:LO_W];
    ish2_r  <= ish_r;
    prod_r  <= UNI_W'(pp_lo_r) + {pp_hi_r, {LO_W{1'b0}}};
    ish3_r  <= ish2_r;
  end

  // result word
  logic      out_strobe_r;
  out_item_t out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.finish;
    end
    if (cmd.finish) begin
      out_item_r.kept           <= keep && !full;
      out_item_r.box_position   <= pos_r;
      out_item_r.store_overflow <= keep && full;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  assign stat.count_zero = (count_r == '0);
  assign stat.scan_last  = ((CNT_W'(idx_r) + 1'b1) == count_r);
  assign stat.pipe_busy  = |v_r;

endmodule

FILE: src/greedy_box_nms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_box_nms_core
// Greedy IoU non-maximum suppression over score-sorted boxes.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_item and raise start; the word is taken at a clock edge
//   where start is high and busy is low. start_of_set in the word clears the
//   kept list and position counter before that box is handled.
//   Output: each box yields one result word on out_item, marked by out_strobe
//   for exactly one cycle. The receiver cannot stall; it must take it.
//   Config: cfg_we with cfg_wdata writes iou_threshold (Q0.16); the user
//   must write only while busy is low and no result is pending; not enforced.
//   Timing: with N kept boxes in the set (up to MAX_KEPT), all N entries are
//   scanned before the strobe rises; an empty set skips the scan.
//   The compare pipe reads one kept entry per cycle from the single-read-port
//   store, then drains its six stages. busy is low again the cycle the
//   strobe rises, so one box is in flight at a time.
//   Reset: synchronous, rst_n low; clears the kept count, position counter
//   and threshold (to about 0.45). Stored boxes need no clearing.
// ----------------------------------------------------------------------------
module greedy_box_nms_core #(
  parameter int MAX_KEPT   = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  gbn_pkg::in_item_t         in_item,
  output logic                      out_strobe,
  output gbn_pkg::out_item_t        out_item,
  input  logic                      cfg_we,
  input  logic [gbn_pkg::THR_W-1:0] cfg_wdata
);
  import gbn_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  gbn_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  gbn_datapath #(
    .MAX_KEPT   (MAX_KEPT),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

FILE: dv/tb_greedy_box_nms_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_greedy_box_nms_core
// Self-checking bench for the greedy box NMS core. A short table of directed
// boxes runs first, then random sets of clustered, scattered and disjoint
// boxes under several IoU thresholds and sender idle rates. Result words
// are checked against a row's literal result or an in-bench kept-store model.
// ----------------------------------------------------------------------------
module tb_greedy_box_nms_core;
  import gbn_pkg::*;

  localparam int MAX_KEPT    = 64;
  localparam int NUM_DIR     = 21;
  localparam int CYCLE_LIMIT = 1_000_000;

  typedef struct packed {
    logic      lit;
    out_item_t res;
    in_item_t  word;
  } dir_row_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  in_item_t           in_item;
  logic               out_strobe;
  out_item_t          out_item;
  logic               cfg_we;
  logic [THR_W-1:0]   cfg_wdata;

  // model of the kept store
  logic [FIELD_W-1:0] kept_left [MAX_KEPT];
  logic [FIELD_W-1:0] kept_top  [MAX_KEPT];
  logic [FIELD_W-1:0] kept_wid  [MAX_KEPT];
  logic [FIELD_W-1:0] kept_hgt  [MAX_KEPT];
  logic [31:0]        kept_area [MAX_KEPT];
  int                 kept_num;
  logic [POS_W-1:0]   set_pos;
  logic [THR_W-1:0]   thr_q;

  out_item_t          expected_results[$];
  out_item_t          oldest;
  dir_row_t           dir_rows [NUM_DIR];
  int                 n_fail;
  int                 n_sent;
  int                 idle_pct;
  int                 cycle_count;

  greedy_box_nms_core #(
    .MAX_KEPT  (MAX_KEPT),
    .COORD_BITS(FIELD_W)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] span_overlap(logic [63:0] a0, logic [63:0] alen,
                                               logic [63:0] b0, logic [63:0] blen);
    logic [63:0] a1;
    logic [63:0] b1;
    logic [63:0] lo;
    logic [63:0] hi;
    a1 = a0 + alen;
    b1 = b0 + blen;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a1 < b1) ? a1 : b1;
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  // Greedy IoU test of one box against the kept store; updates the store.
  function automatic out_item_t nms_predict(in_item_t w);
    logic [63:0] bw;
    logic [63:0] bh;
    logic [63:0] area;
    logic [63:0] inter;
    logic [63:0] uni;
    logic [63:0] thr64;
    logic        keep;
    out_item_t   r;
    keep  = 1'b1;
    thr64 = 64'(thr_q);
    bw    = 64'(w.box_width);
    bh    = 64'(w.box_height);
    if (w.start_of_set) begin
      kept_num = 0;
      set_pos  = '0;
    end
    area = bw * bh;
    for (int k = 0; k < kept_num; k++) begin
      inter = span_overlap(64'(w.box_left), bw, 64'(kept_left[k]), 64'(kept_wid[k])) *
              span_overlap(64'(w.box_top), bh, 64'(kept_top[k]), 64'(kept_hgt[k]));
      uni   = area + 64'(kept_area[k]) - inter;
      if ((inter << 16) > thr64 * uni) keep = 1'b0;
    end
    r.kept           = 1'b0;
    r.box_position   = set_pos;
    r.store_overflow = 1'b0;
    set_pos          = set_pos + 1'b1;
    if (keep) begin
      if (kept_num < MAX_KEPT) begin
        kept_left[kept_num] = w.box_left;
        kept_top[kept_num]  = w.box_top;
        kept_wid[kept_num]  = w.box_width;
        kept_hgt[kept_num]  = w.box_height;
        kept_area[kept_num] = area[31:0];
        kept_num++;
        r.kept = 1'b1;
      end else begin
        r.store_overflow = 1'b1;
      end
    end
    return r;
  endfunction

  // Hand one word to the core; returns at the edge that accepts it.
  task automatic send_word(in_item_t w, logic lit, out_item_t lit_res);
    out_item_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = nms_predict(w);
    expected_results.insert(expected_results.size(), lit ? lit_res : pred);
    n_sent++;
  endtask

  task automatic wait_all_results();
    start <= 1'b0;
    while (expected_results.size() != 0 || busy) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THR_W-1:0] v);
    wait_all_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    thr_q  = v;
    cfg_we <= 1'b0;
  endtask

  // Boxes jittered around one center: mix of kept and suppressed.
  task automatic random_cluster();
    int       n;
    int       cx;
    int       cy;
    int       bw;
    int       bh;
    in_item_t w;
    n  = $urandom_range(1, 16);
    cx = $urandom_range(0, 65535);
    cy = $urandom_range(0, 65535);
    bw = $urandom_range(4, 8000);
    bh = $urandom_range(4, 8000);
    for (int i = 0; i < n; i++) begin
      w.start_of_set = (i == 0) && ($urandom_range(9) != 0);
      w.box_left     = FIELD_W'(cx + $urandom_range(0, bw / 3));
      w.box_top      = FIELD_W'(cy + $urandom_range(0, bh / 3));
      w.box_width    = FIELD_W'(bw - $urandom_range(0, bw / 4) + $urandom_range(0, bw / 4));
      w.box_height   = FIELD_W'(bh - $urandom_range(0, bh / 4) + $urandom_range(0, bh / 4));
      if ($urandom_range(19) == 0) w.box_width = '0;
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic random_scatter(int n);
    in_item_t w;
    for (int i = 0; i < n; i++) begin
      w.start_of_set = 1'($urandom_range(1));
      w.box_left     = FIELD_W'($urandom);
      w.box_top      = FIELD_W'($urandom);
      w.box_width    = FIELD_W'($urandom);
      w.box_height   = FIELD_W'($urandom);
      send_word(w, 1'b0, '0);
    end
  endtask

  // Disjoint columns fill the store, then push it past full.
  task automatic random_fill();
    in_item_t w;
    for (int k = 0; k < MAX_KEPT + 4; k++) begin
      w.start_of_set = (k == 0);
      w.box_left     = FIELD_W'(k * 900);
      w.box_top      = FIELD_W'($urandom);
      w.box_width    = FIELD_W'($urandom_range(0, 900));
      w.box_height   = FIELD_W'($urandom);
      send_word(w, 1'b0, '0);
    end
    for (int i = 0; i < 4; i++) begin
      w.start_of_set = 1'b0;
      w.box_left     = FIELD_W'($urandom);
      w.box_top      = FIELD_W'($urandom);
      w.box_width    = FIELD_W'($urandom);
      w.box_height   = FIELD_W'($urandom);
      send_word(w, 1'b0, '0);
    end
  endtask

  task automatic run_random(int n);
    int target;
    int kind;
    target = n_sent + n;
    random_fill();
    while (n_sent < target) begin
      kind = $urandom_range(0, 29);
      if (kind == 29) random_fill();
      else if (kind >= 22) random_scatter($urandom_range(1, 6));
      else random_cluster();
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (expected_results.size() == 0) begin
        n_fail++;
        if (n_fail <= 10) $display("unexpected result word %p", out_item);
      end else begin
        oldest = expected_results.pop_front();
        if (out_item !== oldest) begin
          n_fail++;
          if (n_fail <= 10)
            $display("mismatch: kept %b/%b pos %0d/%0d overflow %b/%b (exp/act)",
                     oldest.kept, out_item.kept, oldest.box_position,
                     out_item.box_position, oldest.store_overflow,
                     out_item.store_overflow);
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    n_fail    = 0;
    n_sent    = 0;
    idle_pct  = 9;
    kept_num  = 0;
    set_pos   = '0;
    thr_q     = THR_RESET;

    // lit, {kept, position, overflow}, {start_of_set, left, top, width, height}
    dir_rows[0]  = '{1'b1, '{1'b1, 16'd0, 1'b0}, '{1'b1, 16'd0, 16'd0, 16'd0, 16'd0}};
    // zero union never suppresses
    dir_rows[1]  = '{1'b1, '{1'b1, 16'd1, 1'b0}, '{1'b0, 16'd0, 16'd0, 16'd0, 16'd0}};
    dir_rows[2]  = '{1'b1, '{1'b1, 16'd0, 1'b0},
                     '{1'b1, 16'd16, 16'd16, 16'd160, 16'd160}};
    // identical box
    dir_rows[3]  = '{1'b1, '{1'b0, 16'd1, 1'b0},
                     '{1'b0, 16'd16, 16'd16, 16'd160, 16'd160}};
    // touching edge, no intersection
    dir_rows[4]  = '{1'b1, '{1'b1, 16'd2, 1'b0},
                     '{1'b0, 16'd176, 16'd16, 16'd160, 16'd160}};
    dir_rows[5]  = '{1'b0, '0, '{1'b0, 16'd96, 16'd16, 16'd160, 16'd160}};
    dir_rows[6]  = '{1'b0, '0, '{1'b0, 16'd100, 16'd20, 16'd150, 16'd150}};
    dir_rows[7]  = '{1'b0, '0, '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}};
    dir_rows[8]  = '{1'b0, '0, '{1'b0, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF}};
    dir_rows[9]  = '{1'b0, '0, '{1'b0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}};
    dir_rows[10] = '{1'b1, '{1'b1, 16'd0, 1'b0},
                     '{1'b1, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF}};
    dir_rows[11] = '{1'b0, '0, '{1'b0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1}};
    dir_rows[12] = '{1'b0, '0, '{1'b0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF}};
    dir_rows[13] = '{1'b0, '0, '{1'b0, 16'd0, 16'd0, 16'd0, 16'hFFFF}};
    dir_rows[14] = '{1'b0, '0, '{1'b0, 16'd1, 16'd1, 16'hFFFE, 16'hFFFE}};
    dir_rows[15] = '{1'b1, '{1'b1, 16'd0, 1'b0},
                     '{1'b1, 16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA}};
    dir_rows[16] = '{1'b0, '0, '{1'b0, 16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555}};
    dir_rows[17] = '{1'b1, '{1'b1, 16'd0, 1'b0}, '{1'b1, 16'd0, 16'd0, 16'd16, 16'd16}};
    dir_rows[18] = '{1'b0, '0, '{1'b0, 16'd8, 16'd0, 16'd16, 16'd16}};
    dir_rows[19] = '{1'b0, '0, '{1'b0, 16'd4, 16'd0, 16'd16, 16'd16}};
    dir_rows[20] = '{1'b0, '0, '{1'b0, 16'd0, 16'd0, 16'd16, 16'd16}};

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows run at the reset threshold
    for (int i = 0; i < NUM_DIR; i++)
      send_word(dir_rows[i].word, dir_rows[i].lit, dir_rows[i].res);

    write_threshold(16'hFFFF);
    run_random(170);
    write_threshold(THR_W'($urandom_range(0, 65535)));
    run_random(170);

    idle_pct = 63;
    write_threshold(16'h4000);
    run_random(170);
    write_threshold(THR_RESET);
    run_random(170);

    idle_pct = 0;
    write_threshold(THR_W'($urandom_range(0, 65535)));
    run_random(170);
    write_threshold(16'h0000);
    run_random(170);

    wait_all_results();
    repeat (MAX_KEPT + 20) @(posedge clk);
    if (expected_results.size() != 0) begin
      n_fail++;
      $display("%0d result words never arrived", expected_results.size());
    end
    if (n_fail == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
